[hdl/htfl_pkg.sv]
`default_nettype none

package htfl_pkg;

    localparam int MAX_OBJECTS = 1024;
    localparam int IDX_W       = (MAX_OBJECTS > 2) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 10;
    localparam int LIB_W    = 16;
    localparam int ST_W     = 2;
    localparam int COUNT_W  = 11;
    localparam int CMP_W    = (HANDLE_W > CNT_W) ? HANDLE_W : CNT_W;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_OBJECTS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_OBJECTS - 1);

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DISP     = 11'b000_0000_0100,
        S_AL_POP   = 11'b000_0000_1000,
        S_AL_WR    = 11'b000_0001_0000,
        S_MAP_RD   = 11'b000_0010_0000,
        S_LIB_RD   = 11'b000_0100_0000,
        S_ER_UPD   = 11'b000_1000_0000,
        S_WALK     = 11'b001_0000_0000,
        S_WALK_END = 11'b010_0000_0000,
        S_EMIT     = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic             live;
        logic [IDX_W-1:0] pos;
    } t_map_ent;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_map_ent         wdata;
        logic [IDX_W-1:0] raddr;
    } t_map_req;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_free_req;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [LIB_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_lib_req;

    typedef struct packed {
        logic             valid;
        t_map_ent         ent;
        logic [LIB_W-1:0] dense;
        logic [CNT_W-1:0] idx;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] live;
    } t_walk_in;

    typedef struct packed {
        logic             map_we;
        t_map_ent         map_wdata;
        logic             dense_we;
        logic [LIB_W-1:0] dense_wdata;
    } t_walk_out;

endpackage

`default_nettype wire

[hdl/htfl_ram.sv]
`default_nettype none

module htfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/htfl_walk.sv]
`default_nettype none

module htfl_walk import htfl_pkg::*; (
    input  wire t_walk_in i_walk,
    output t_walk_out     o_walk
);

    always_comb begin
        o_walk = '0;
        if (i_walk.valid) begin
            // mappings above the removed position move down one
            if (i_walk.ent.live && (i_walk.ent.pos > i_walk.pos)) begin
                o_walk.map_we         = 1'b1;
                o_walk.map_wdata.live = 1'b1;
                o_walk.map_wdata.pos  = i_walk.ent.pos - 1'b1;
            end
            // dense entries after the removed one shift down
            if ((CNT_W'(i_walk.pos) <= i_walk.idx) && ((i_walk.idx + 1'b1) < i_walk.live)) begin
                o_walk.dense_we    = 1'b1;
                o_walk.dense_wdata = i_walk.dense;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/htfl_ctrl.sv]
`default_nettype none

module htfl_ctrl import htfl_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [OP_W-1:0]     i_opcode,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [LIB_W-1:0]    i_lib_index,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [ST_W-1:0]          o_status,
    output logic [HANDLE_W-1:0]      o_handle_out,
    output logic [HANDLE_W-1:0]      o_dense_index,
    output logic [LIB_W-1:0]         o_lib_out,
    output logic [COUNT_W-1:0]       o_count_out,
    output t_map_req                 o_map_req,
    input  wire t_map_ent            i_map_rdata,
    output t_free_req                o_free_req,
    input  wire logic [IDX_W-1:0]    i_free_rdata,
    output t_lib_req                 o_lib_req,
    input  wire logic [LIB_W-1:0]    i_lib_rdata
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_free_top, n_free_top;
    logic [CNT_W-1:0] r_issued, n_issued;
    logic [CNT_W-1:0] r_live, n_live;
    logic             r_out_valid, n_out_valid;
    logic             r_wv, n_wv;
    logic [CNT_W-1:0] r_widx, n_widx;

    logic [OP_W-1:0]     r_op, n_op;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [LIB_W-1:0]    r_lib, n_lib;
    logic [IDX_W-1:0]    r_hnd, n_hnd;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [LIB_W-1:0]    r_val, n_val;
    logic [ST_W-1:0]     r_st, n_st;
    logic [HANDLE_W-1:0] r_hout, n_hout;

    logic [ST_W-1:0]     r_o_status, n_o_status;
    logic [HANDLE_W-1:0] r_o_handle, n_o_handle;
    logic [HANDLE_W-1:0] r_o_dense, n_o_dense;
    logic [LIB_W-1:0]    r_o_lib, n_o_lib;
    logic [COUNT_W-1:0]  r_o_count, n_o_count;

    t_walk_in  walk_in;
    t_walk_out walk_out;

    htfl_walk u_walk (
        .i_walk (walk_in),
        .o_walk (walk_out)
    );

    always_comb begin
        walk_in.valid = r_wv;
        walk_in.ent   = i_map_rdata;
        walk_in.dense = i_lib_rdata;
        walk_in.idx   = r_widx;
        walk_in.pos   = r_pos;
        walk_in.live  = r_live;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_free_top  = r_free_top;
        n_issued    = r_issued;
        n_live      = r_live;
        n_out_valid = r_out_valid && i_out_stall;
        n_wv        = 1'b0;
        n_widx      = r_idx;
        n_op        = r_op;
        n_handle    = r_handle;
        n_lib       = r_lib;
        n_hnd       = r_hnd;
        n_pos       = r_pos;
        n_val       = r_val;
        n_st        = r_st;
        n_hout      = r_hout;
        n_o_status  = r_o_status;
        n_o_handle  = r_o_handle;
        n_o_dense   = r_o_dense;
        n_o_lib     = r_o_lib;
        n_o_count   = r_o_count;
        o_map_req   = '0;
        o_free_req  = '0;
        o_lib_req   = '0;

        if (walk_out.map_we) begin
            o_map_req.we    = 1'b1;
            o_map_req.waddr = IDX_W'(r_widx);
            o_map_req.wdata = walk_out.map_wdata;
        end
        if (walk_out.dense_we) begin
            o_lib_req.we    = 1'b1;
            o_lib_req.waddr = IDX_W'(r_widx);
            o_lib_req.wdata = walk_out.dense_wdata;
        end

        case (r_state)
            S_CLEAR: begin
                o_map_req.we    = 1'b1;
                o_map_req.waddr = IDX_W'(r_idx);
                o_map_req.wdata = '0;
                if (r_idx == LAST_CNT) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_handle = i_handle;
                    n_lib    = i_lib_index;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (r_op == OP_ALLOC) begin
                    if ((r_live >= MAX_CNT) ||
                        ((r_free_top == '0) && (r_issued >= MAX_CNT))) begin
                        n_st    = ST_FULL;
                        n_hout  = '0;
                        n_pos   = '0;
                        n_val   = '0;
                        n_state = S_EMIT;
                    end else if (r_free_top != '0) begin
                        o_free_req.raddr = IDX_W'(r_free_top - 1'b1);
                        n_state          = S_AL_POP;
                    end else begin
                        n_hnd    = IDX_W'(r_issued);
                        n_issued = r_issued + 1'b1;
                        n_state  = S_AL_WR;
                    end
                end else if (CMP_W'(r_handle) >= CMP_W'(MAX_OBJECTS)) begin
                    n_st    = ST_BAD;
                    n_hout  = r_handle;
                    n_pos   = '0;
                    n_val   = '0;
                    n_state = S_EMIT;
                end else begin
                    o_map_req.raddr = IDX_W'(r_handle);
                    n_hnd           = IDX_W'(r_handle);
                    n_state         = S_MAP_RD;
                end
            end
            S_AL_POP: begin
                n_hnd      = i_free_rdata;
                n_free_top = r_free_top - 1'b1;
                n_state    = S_AL_WR;
            end
            S_AL_WR: begin
                o_map_req.we         = 1'b1;
                o_map_req.waddr      = r_hnd;
                o_map_req.wdata.live = 1'b1;
                o_map_req.wdata.pos  = IDX_W'(r_live);
                o_lib_req.we         = 1'b1;
                o_lib_req.waddr      = IDX_W'(r_live);
                o_lib_req.wdata      = r_lib;
                n_st                 = ST_OK;
                n_hout               = HANDLE_W'(r_hnd);
                n_pos                = IDX_W'(r_live);
                n_val                = r_lib;
                n_live               = r_live + 1'b1;
                n_state              = S_EMIT;
            end
            S_MAP_RD: begin
                if (!i_map_rdata.live) begin
                    n_st    = ST_BAD;
                    n_hout  = r_handle;
                    n_pos   = '0;
                    n_val   = '0;
                    n_state = S_EMIT;
                end else begin
                    o_lib_req.raddr = i_map_rdata.pos;
                    n_pos           = i_map_rdata.pos;
                    n_state         = S_LIB_RD;
                end
            end
            S_LIB_RD: begin
                n_val  = i_lib_rdata;
                n_st   = ST_OK;
                n_hout = r_handle;
                if (r_op == OP_ERASE) begin
                    n_state = S_ER_UPD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_ER_UPD: begin
                if (r_free_top < MAX_CNT) begin
                    o_free_req.we    = 1'b1;
                    o_free_req.waddr = IDX_W'(r_free_top);
                    o_free_req.wdata = r_hnd;
                    n_free_top       = r_free_top + 1'b1;
                end
                o_map_req.we    = 1'b1;
                o_map_req.waddr = r_hnd;
                o_map_req.wdata = '0;
                n_idx           = '0;
                n_state         = S_WALK;
            end
            S_WALK: begin
                // read entry idx while the unit writes back entry idx - 1
                o_map_req.raddr = IDX_W'(r_idx);
                o_lib_req.raddr = IDX_W'(r_idx + 1'b1);
                n_wv            = 1'b1;
                n_widx          = r_idx;
                if (r_idx == LAST_CNT) begin
                    n_idx   = '0;
                    n_state = S_WALK_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WALK_END: begin
                n_live  = r_live - 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_o_status  = r_st;
                    n_o_handle  = r_hout;
                    n_o_dense   = HANDLE_W'(r_pos);
                    n_o_lib     = r_val;
                    n_o_count   = COUNT_W'(r_live);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_free_top  <= '0;
            r_issued    <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_free_top  <= n_free_top;
            r_issued    <= n_issued;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            r_wv        <= n_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx     <= n_widx;
        r_op       <= n_op;
        r_handle   <= n_handle;
        r_lib      <= n_lib;
        r_hnd      <= n_hnd;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_st       <= n_st;
        r_hout     <= n_hout;
        r_o_status <= n_o_status;
        r_o_handle <= n_o_handle;
        r_o_dense  <= n_o_dense;
        r_o_lib    <= n_o_lib;
        r_o_count  <= n_o_count;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_handle_out  = r_o_handle;
    assign o_dense_index = r_o_dense;
    assign o_lib_out     = r_o_lib;
    assign o_count_out   = r_o_count;

endmodule

`default_nettype wire

[hdl/handle_table_with_free_list_unit.sv]
// Stable-handle table over a compacted object array. Allocate takes the most recently
// freed handle (or the next fresh one), maps it to the end of the dense array and stores
// the library index there; erase frees the handle, shifts later dense entries down and
// moves every mapping above the removed position down one; lookup returns the dense
// position and library index of a live handle. One word is worked on at a time and
// o_in_stall stays high until its result is in the output register, which holds while
// the next word is taken. Lookup reads the handle map and then the dense array; a bad
// handle skips the dense read. Allocate pops the free list when it is not empty and goes
// straight to its answer when the table is full. Erase walks the whole handle map,
// one entry a cycle through the shared compare and decrement unit, which
// shifts the dense array in the same pass. A stalled output register holds the result
// back. After reset the handle map is cleared one entry a cycle, and no word is taken
// until every entry has been cleared.
`default_nettype none

module handle_table_with_free_list_unit import htfl_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [OP_W-1:0]     i_opcode,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [LIB_W-1:0]    i_lib_index,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [ST_W-1:0]          o_status,
    output logic [HANDLE_W-1:0]      o_handle_out,
    output logic [HANDLE_W-1:0]      o_dense_index,
    output logic [LIB_W-1:0]         o_lib_out,
    output logic [COUNT_W-1:0]       o_count_out
);

    t_map_req         map_req;
    t_map_ent         map_rdata;
    t_free_req        free_req;
    logic [IDX_W-1:0] free_rdata;
    t_lib_req         lib_req;
    logic [LIB_W-1:0] lib_rdata;

    htfl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_handle      (i_handle),
        .i_lib_index   (i_lib_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_handle_out  (o_handle_out),
        .o_dense_index (o_dense_index),
        .o_lib_out     (o_lib_out),
        .o_count_out   (o_count_out),
        .o_map_req     (map_req),
        .i_map_rdata   (map_rdata),
        .o_free_req    (free_req),
        .i_free_rdata  (free_rdata),
        .o_lib_req     (lib_req),
        .i_lib_rdata   (lib_rdata)
    );

    htfl_ram #(
        .WIDTH ($bits(t_map_ent)),
        .DEPTH (MAX_OBJECTS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_req.we),
        .i_waddr (map_req.waddr),
        .i_wdata (map_req.wdata),
        .i_raddr (map_req.raddr),
        .o_rdata (map_rdata)
    );

    htfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_OBJECTS)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_req.we),
        .i_waddr (free_req.waddr),
        .i_wdata (free_req.wdata),
        .i_raddr (free_req.raddr),
        .o_rdata (free_rdata)
    );

    htfl_ram #(
        .WIDTH (LIB_W),
        .DEPTH (MAX_OBJECTS)
    ) u_lib_ram (
        .i_clk   (i_clk),
        .i_we    (lib_req.we),
        .i_waddr (lib_req.waddr),
        .i_wdata (lib_req.wdata),
        .i_raddr (lib_req.raddr),
        .o_rdata (lib_rdata)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import htfl_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 10000;
    localparam int RANDOM_WORDS = 550;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
        logic [LIB_W-1:0]    lib;
    } t_table_word;

    typedef struct packed {
        logic [ST_W-1:0]     status;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] dense;
        logic [LIB_W-1:0]    lib;
        logic [COUNT_W-1:0]  count;
    } t_table_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     opcode = OP_LOOKUP;
    logic [HANDLE_W-1:0] handle = '0;
    logic [LIB_W-1:0]    lib_index = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [ST_W-1:0]     status;
    logic [HANDLE_W-1:0] handle_out;
    logic [HANDLE_W-1:0] dense_index;
    logic [LIB_W-1:0]    lib_out;
    logic [COUNT_W-1:0]  count_out;

    t_table_word   word_q [$];
    t_table_answer answer_q [$];

    // predicted table state
    logic [HANDLE_W-1:0] pos_of [MAX_OBJECTS];
    bit                  live_of [MAX_OBJECTS];
    logic [HANDLE_W-1:0] freed_q [$];
    logic [LIB_W-1:0]    dense_q [$];
    int                  fresh_next = 0;

    int n_queued = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int gap_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    handle_table_with_free_list_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_handle      (handle),
        .i_lib_index   (lib_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_handle_out  (handle_out),
        .o_dense_index (dense_index),
        .o_lib_out     (lib_out),
        .o_count_out   (count_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void apply_table_op(input logic [OP_W-1:0] op,
                                           input logic [HANDLE_W-1:0] h,
                                           input logic [LIB_W-1:0] lib);
        t_table_answer a;
        int p;
        a.status = ST_OK;
        a.handle = h;
        a.dense  = '0;
        a.lib    = '0;
        if (op == OP_ALLOC) begin
            if (dense_q.size() >= MAX_OBJECTS) begin
                a.status = ST_FULL;
                a.handle = '0;
            end else begin
                if (freed_q.size() != 0) begin
                    a.handle = freed_q[freed_q.size() - 1];
                    freed_q.delete(freed_q.size() - 1);
                end else begin
                    a.handle = HANDLE_W'(fresh_next);
                    fresh_next++;
                end
                pos_of[a.handle]  = HANDLE_W'(dense_q.size());
                live_of[a.handle] = 1'b1;
                a.dense = pos_of[a.handle];
                a.lib   = lib;
                dense_q.insert(dense_q.size(), lib);
            end
        end else if (!live_of[h]) begin
            a.status = ST_BAD;
        end else begin
            p = int'(pos_of[h]);
            a.dense = pos_of[h];
            a.lib   = dense_q[p];
            if (op == OP_ERASE) begin
                freed_q.insert(freed_q.size(), h);
                live_of[h] = 1'b0;
                for (int i = 0; i < MAX_OBJECTS; i++) begin
                    if (live_of[i] && pos_of[i] > a.dense) pos_of[i]--;
                end
                dense_q.delete(p);
            end
        end
        a.count = COUNT_W'(dense_q.size());
        answer_q.insert(answer_q.size(), a);
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_live();
        logic [HANDLE_W-1:0] pool [$];
        for (int i = 0; i < MAX_OBJECTS; i++) begin
            if (live_of[i]) pool.insert(pool.size(), HANDLE_W'(i));
        end
        if (pool.size() == 0) return HANDLE_W'($urandom);
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    function automatic logic [HANDLE_W-1:0] aim_handle();
        if ($urandom_range(0, 7) == 0) return HANDLE_W'($urandom);
        return pick_live();
    endfunction

    task automatic queue_word(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                              input logic [LIB_W-1:0] lib);
        t_table_word w;
        w.op     = op;
        w.handle = h;
        w.lib    = lib;
        word_q.insert(word_q.size(), w);
        n_queued++;
    endtask

    task automatic wait_accepted();
        while (n_accepted != n_queued) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        t_table_word w;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_table_op(opcode, handle, lib_index);
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (word_q.size() != 0) begin
                    w = word_q.pop_front();
                    opcode    <= w.op;
                    handle    <= w.handle;
                    lib_index <= w.lib;
                    in_valid  <= 1'b1;
                    gap_left  <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : stall_gen
        int g;
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            g = pick_gap();
            out_stall <= (g != 0);
            hold_left <= (g != 0) ? g - 1 : 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check
        t_table_answer a;
        if (i_rst_n && out_valid && !out_stall) begin
            if (answer_q.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
            end else begin
                a = answer_q.pop_front();
                if (a.status !== status) begin
                    $error("status: expected %0d, got %0d", a.status, status);
                    n_errors++;
                end
                if (a.handle !== handle_out) begin
                    $error("handle_out: expected %0d, got %0d", a.handle, handle_out);
                    n_errors++;
                end
                if (a.dense !== dense_index) begin
                    $error("dense_index: expected %0d, got %0d", a.dense, dense_index);
                    n_errors++;
                end
                if (a.lib !== lib_out) begin
                    $error("lib_out: expected %0d, got %0d", a.lib, lib_out);
                    n_errors++;
                end
                if (a.count !== count_out) begin
                    $error("count_out: expected %0d, got %0d", a.count, count_out);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n_rand;
        int batch;
        int r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, growth, middle, first and last erase, reuse
        queue_word(OP_LOOKUP, 10'd0, 16'h0000);
        queue_word(OP_ERASE, 10'd1023, 16'hffff);
        queue_word(OP_ALLOC, 10'd1023, 16'h0000);
        queue_word(OP_ALLOC, 10'd0, 16'hffff);
        queue_word(OP_ALLOC, 10'd512, 16'h1234);
        queue_word(OP_ALLOC, 10'd0, 16'haaaa);
        queue_word(OP_LOOKUP, 10'd1, 16'h0000);
        queue_word(OP_SPARE, 10'd2, 16'hffff);
        queue_word(OP_ERASE, 10'd1, 16'h0000);
        queue_word(OP_LOOKUP, 10'd2, 16'h0000);
        queue_word(OP_LOOKUP, 10'd3, 16'h0000);
        queue_word(OP_ERASE, 10'd1, 16'h0000);
        queue_word(OP_ALLOC, 10'd0, 16'h5555);
        queue_word(OP_ERASE, 10'd1, 16'h0000);
        queue_word(OP_ERASE, 10'd0, 16'h0000);
        queue_word(OP_ALLOC, 10'd0, 16'h8001);
        queue_word(OP_SPARE, 10'd1023, 16'h0000);
        queue_word(OP_ERASE, 10'd3, 16'h0000);
        queue_word(OP_ERASE, 10'd2, 16'h0000);
        queue_word(OP_ERASE, 10'd0, 16'h0000);
        queue_word(OP_LOOKUP, 10'd0, 16'h0000);

        n_rand = 0;
        while (n_rand < RANDOM_WORDS) begin
            wait_accepted();
            calm = ($urandom_range(0, 6) == 0);
            batch = $urandom_range(1, 4);
            repeat (batch) begin
                r = $urandom_range(0, 99);
                if (dense_q.size() == 0 || r < 38)
                    queue_word(OP_ALLOC, HANDLE_W'($urandom), LIB_W'($urandom));
                else if (r < 62)
                    queue_word(OP_ERASE, aim_handle(), LIB_W'($urandom));
                else if (r < 94)
                    queue_word(OP_LOOKUP, aim_handle(), LIB_W'($urandom));
                else
                    queue_word(OP_SPARE, aim_handle(), LIB_W'($urandom));
            end
            n_rand += batch;
        end

        // edge handles after the random run
        wait_accepted();
        calm = 1'b0;
        queue_word(OP_ALLOC, 10'd0, 16'hffff);
        queue_word(OP_ALLOC, 10'd1023, 16'h0000);
        queue_word(OP_LOOKUP, 10'd1023, 16'h0000);
        queue_word(OP_SPARE, 10'd0, 16'h0000);
        queue_word(OP_ERASE, 10'd0, 16'h0000);
        queue_word(OP_ALLOC, 10'd0, 16'hc3c3);
        queue_word(OP_ALLOC, 10'd0, 16'h0000);
        queue_word(OP_ERASE, 10'd1023, 16'h0000);
        queue_word(OP_LOOKUP, 10'd0, 16'h0000);

        wait_accepted();
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
